// ===== sv/ohbe_pkg.sv =====
// ----------------------------------------------------------------------------
// One-hot bin encoder package
// Shared field widths, command and kind codes, and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package ohbe_pkg;

    // Field widths of one input word and one result word
    localparam int CMD_W   = 2;
    localparam int COL_W   = 6;
    localparam int SLOT_W  = 5;
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 6;
    localparam int BASE_W  = 12;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 12;

    // Size of the one-hot output vector; positions wrap modulo this
    localparam int OUTPUTS = 4096;
    localparam int OUT_W   = $clog2(OUTPUTS);

    // Command codes
    localparam logic [CMD_W-1:0] OP_SET_DESC = 2'd0;
    localparam logic [CMD_W-1:0] OP_WR_ENTRY = 2'd1;
    localparam logic [CMD_W-1:0] OP_ENCODE   = 2'd2;

    // Column kinds; the unused code behaves as ignored
    localparam logic [KIND_W-1:0] KIND_IGNORED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISCRETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NUMERIC  = 2'd2;

    // Source of the bin index added to the column base
    typedef enum logic [1:0] {
        IDX_ZERO,
        IDX_CMP,
        IDX_CNT
    } t_idx_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     load;        // capture the input word
        logic     clr;         // clear one descriptor entry
        logic     desc_we;     // write the column descriptor
        logic     entry_we;    // write one table entry
        logic     desc_latch;  // latch the descriptor read back
        logic     ld_last;     // point the entry read at the last entry
        logic     rd_zero;     // point the entry read at entry zero
        logic     scan_start;  // first compare of the scan
        logic     scan_step;   // advance the scan by one entry
        logic     res_set;     // load the result register
        logic     res_hit;     // result carries a set bit
        t_idx_sel res_sel;     // bin index source
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic              clr_last;    // clearing pass on its last entry
        logic [KIND_W-1:0] kind;        // latched column kind
        logic              cnt_zero;    // column holds no entries
        logic              match;       // current entry matches the value
        logic              last;        // current entry is the column's last
        logic              below_last;  // value is below the current entry
    } t_dp_sts;

endpackage

// ===== sv/one_hot_bin_encoder_top.sv =====
// ----------------------------------------------------------------------------
// One-hot bin encoder, top level
// Maps a column value to the position of its one-hot bit using per-column
// descriptors and a table of sorted values or thresholds.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. After reset busy stays
// high while the descriptor store is cleared. A descriptor or table write
// keeps busy high while the write is made. An encode keeps it high while the
// single comparator steps through up to n words of the column's row of the
// entry RAM one word per cycle, n being the column's entry count, which is
// at most ENTRIES. Each encode returns one result word, shown on o_position
// and o_hit for a single cycle with o_valid high, in the cycle busy falls;
// the receiver must take it then. The entry store has no reset: encode only
// columns whose entries have been written.
module one_hot_bin_encoder_top #(
    parameter int COLUMNS = 64,
    parameter int ENTRIES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ohbe_pkg::CMD_W-1:0]          i_cmd,
    input  logic [ohbe_pkg::COL_W-1:0]          i_column,
    input  logic [ohbe_pkg::SLOT_W-1:0]         i_slot,
    input  logic [ohbe_pkg::KIND_W-1:0]         i_kind,
    input  logic [ohbe_pkg::CNT_W-1:0]          i_entry_count,
    input  logic [ohbe_pkg::BASE_W-1:0]         i_base,
    input  logic signed [ohbe_pkg::VAL_W-1:0]   i_value,
    output logic [ohbe_pkg::POS_W-1:0]          o_position,
    output logic                                o_hit,
    output logic                                o_valid
);

    import ohbe_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Controller
    ohbe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_cmd),
        .i_sts    (dp_sts),
        .o_dp_cmd (dp_cmd),
        .o_busy   (busy)
    );

    // Datapath
    ohbe_dp #(
        .COLUMNS (COLUMNS),
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .o_sts         (dp_sts),
        .i_column      (i_column),
        .i_slot        (i_slot),
        .i_kind        (i_kind),
        .i_entry_count (i_entry_count),
        .i_base        (i_base),
        .i_value       (i_value),
        .o_position    (o_position),
        .o_hit         (o_hit),
        .o_valid       (o_valid)
    );

    // Result strobe only appears once the block is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Writes and unknown commands never produce a result word
    a_no_result_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd != OP_ENCODE) |=> !o_valid)
        else $error("result word after a non-encode command");

    // A miss carries a zero position
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_position == '0))
        else $error("miss with nonzero position");

    // A write or an encode raises busy after the accepting edge;
    // an unknown command is dropped without raising busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == OP_SET_DESC || i_cmd == OP_WR_ENTRY
                            || i_cmd == OP_ENCODE)) |=> busy)
        else $error("busy not raised after accept");

endmodule

// ===== sv/ohbe_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ohbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ohbe_dp.sv =====
// ----------------------------------------------------------------------------
// One-hot bin encoder datapath
// Input word registers, descriptor and entry stores, the single entry
// comparator with its scan counters, and the result register.
// ----------------------------------------------------------------------------
module ohbe_dp #(
    parameter int COLUMNS = 64,
    parameter int ENTRIES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ohbe_pkg::t_dp_cmd               i_dp_cmd,
    output ohbe_pkg::t_dp_sts               o_sts,
    input  logic [ohbe_pkg::COL_W-1:0]      i_column,
    input  logic [ohbe_pkg::SLOT_W-1:0]     i_slot,
    input  logic [ohbe_pkg::KIND_W-1:0]     i_kind,
    input  logic [ohbe_pkg::CNT_W-1:0]      i_entry_count,
    input  logic [ohbe_pkg::BASE_W-1:0]     i_base,
    input  logic signed [ohbe_pkg::VAL_W-1:0] i_value,
    output logic [ohbe_pkg::POS_W-1:0]      o_position,
    output logic                            o_hit,
    output logic                            o_valid
);

    import ohbe_pkg::*;

    localparam int ColAw = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int EntAw = $clog2(COLUMNS * ENTRIES);
    localparam int CntW  = $clog2(ENTRIES + 1);
    localparam int DescW = KIND_W + CntW + BASE_W;

    // Captured input word
    logic [COL_W-1:0]        r_column;
    logic [SLOT_W-1:0]       r_slot;
    logic [KIND_W-1:0]       r_kind_in;
    logic [CNT_W-1:0]        r_cnt_in;
    logic [BASE_W-1:0]       r_base_in;
    logic signed [VAL_W-1:0] r_value;
    logic [EntAw-1:0]        r_row;

    // Latched descriptor and scan state
    logic [KIND_W-1:0]       r_kind;
    logic [CntW-1:0]         r_cnt;
    logic [BASE_W-1:0]       r_base;
    logic [CntW-1:0]         r_rd_idx;
    logic [CntW-1:0]         r_cmp_idx;
    logic [ColAw-1:0]        r_clr_idx;

    // Result register
    logic [POS_W-1:0]        r_pos;
    logic                    r_hit;
    logic                    r_valid;

    logic                    col_ok;
    logic                    slot_ok;
    logic [CntW-1:0]         cnt_sat;
    logic [ColAw-1:0]        col_addr;
    logic                    desc_we;
    logic [ColAw-1:0]        desc_waddr;
    logic [DescW-1:0]        desc_wdata;
    logic [DescW-1:0]        desc_rdata;
    logic [KIND_W-1:0]       d_kind;
    logic [CntW-1:0]         d_cnt;
    logic [BASE_W-1:0]       d_base;
    logic                    ent_we;
    logic [EntAw-1:0]        ent_waddr;
    logic [EntAw-1:0]        ent_raddr;
    logic [VAL_W-1:0]        ent_rdata;
    logic signed [VAL_W-1:0] ent_val;
    logic [CntW-1:0]         idx_sel;
    logic [BASE_W-1:0]       pos_sum;
    logic [POS_W-1:0]        n_pos;

    // Address range checks and count saturation
    assign col_ok   = 32'(r_column) < COLUMNS;
    assign slot_ok  = 32'(r_slot) < ENTRIES;
    assign cnt_sat  = (32'(r_cnt_in) > ENTRIES) ? CntW'(ENTRIES) : CntW'(r_cnt_in);
    assign col_addr = ColAw'(32'(r_column));

    // Descriptor store: cleared by a sweep after reset
    assign desc_we    = i_dp_cmd.clr | (i_dp_cmd.desc_we & col_ok);
    assign desc_waddr = i_dp_cmd.clr ? r_clr_idx : col_addr;
    assign desc_wdata = i_dp_cmd.clr ? '0 : {r_kind_in, cnt_sat, r_base_in};

    ohbe_ram #(
        .WIDTH (DescW),
        .DEPTH (COLUMNS)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (desc_we),
        .i_waddr (desc_waddr),
        .i_wdata (desc_wdata),
        .i_raddr (col_addr),
        .o_rdata (desc_rdata)
    );

    assign {d_kind, d_cnt, d_base} = desc_rdata;

    // Entry store: one row of ENTRIES words per column
    assign ent_we    = i_dp_cmd.entry_we & col_ok & slot_ok;
    assign ent_waddr = r_row + EntAw'(r_slot);
    assign ent_raddr = r_row + EntAw'(r_rd_idx);

    ohbe_ram #(
        .WIDTH (VAL_W),
        .DEPTH (COLUMNS * ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata ($unsigned(r_value)),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign ent_val = $signed(ent_rdata);

    // Comparator and status
    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = (r_clr_idx == ColAw'(COLUMNS - 1));
        o_sts.kind       = r_kind;
        o_sts.cnt_zero   = (r_cnt == '0);
        o_sts.last       = (r_cmp_idx == r_cnt - CntW'(1));
        o_sts.below_last = (r_value < ent_val);
        if (r_kind == KIND_DISCRETE) begin
            o_sts.match = (r_value == ent_val);
        end else begin
            o_sts.match = (r_value <= ent_val);
        end
    end

    // Bin index select and position add (wraps modulo OUTPUTS)
    always_comb begin
        case (i_dp_cmd.res_sel)
            IDX_CMP: idx_sel = r_cmp_idx;
            IDX_CNT: idx_sel = r_cnt;
            default: idx_sel = '0;
        endcase
    end

    assign pos_sum = r_base + BASE_W'(idx_sel);
    assign n_pos   = i_dp_cmd.res_hit ? POS_W'(pos_sum[OUT_W-1:0]) : '0;

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_column  <= i_column;
            r_slot    <= i_slot;
            r_kind_in <= i_kind;
            r_cnt_in  <= i_entry_count;
            r_base_in <= i_base;
            r_value   <= i_value;
            r_row     <= EntAw'(32'(i_column) * ENTRIES);
        end
        if (i_dp_cmd.desc_latch) begin
            r_kind <= col_ok ? d_kind : KIND_IGNORED;
            r_cnt  <= d_cnt;
            r_base <= d_base;
        end
        if (i_dp_cmd.desc_latch || i_dp_cmd.rd_zero) begin
            r_rd_idx <= '0;
        end else if (i_dp_cmd.ld_last) begin
            r_rd_idx <= r_cnt - CntW'(1);
        end else if (i_dp_cmd.scan_start) begin
            r_rd_idx <= CntW'(1);
        end else if (i_dp_cmd.scan_step) begin
            r_rd_idx <= r_rd_idx + CntW'(1);
        end
        if (i_dp_cmd.scan_start) begin
            r_cmp_idx <= '0;
        end else if (i_dp_cmd.scan_step) begin
            r_cmp_idx <= r_cmp_idx + CntW'(1);
        end
        if (i_dp_cmd.res_set) begin
            r_pos <= n_pos;
            r_hit <= i_dp_cmd.res_hit;
        end
    end

    // Control registers: result strobe and clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_clr_idx <= '0;
        end else begin
            r_valid <= i_dp_cmd.res_set;
            if (i_dp_cmd.clr) begin
                r_clr_idx <= r_clr_idx + ColAw'(1);
            end
        end
    end

    assign o_position = r_pos;
    assign o_hit      = r_hit;
    assign o_valid    = r_valid;

endmodule

// ===== sv/ohbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// One-hot bin encoder controller
// Sequences the descriptor clear, table writes and the entry scan of an
// encode, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ohbe_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ohbe_pkg::CMD_W-1:0] i_op,
    input  ohbe_pkg::t_dp_sts          i_sts,
    output ohbe_pkg::t_dp_cmd          o_dp_cmd,
    output logic                       o_busy
);

    import ohbe_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DESC_WR,
        ST_ENT_WR,
        ST_FETCH,
        ST_DECODE,
        ST_EVAL,
        ST_LAST_WAIT,
        ST_LAST_CMP,
        ST_SCAN
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_busy;
    logic    n_busy;
    logic    accept;
    t_dp_cmd cmd;

    assign accept = i_start & ~r_busy;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.res_sel = IDX_ZERO;
        unique case (r_state)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    unique case (i_op)
                        OP_SET_DESC: n_state = ST_DESC_WR;
                        OP_WR_ENTRY: n_state = ST_ENT_WR;
                        OP_ENCODE:   n_state = ST_FETCH;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DESC_WR: begin
                cmd.desc_we = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_ENT_WR: begin
                cmd.entry_we = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_FETCH: begin
                n_state = ST_DECODE;
            end
            ST_DECODE: begin
                cmd.desc_latch = 1'b1;
                n_state        = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_sts.kind == KIND_DISCRETE && !i_sts.cnt_zero) begin
                    cmd.scan_start = 1'b1;
                    n_state        = ST_SCAN;
                end else if (i_sts.kind == KIND_NUMERIC && !i_sts.cnt_zero) begin
                    cmd.ld_last = 1'b1;
                    n_state     = ST_LAST_WAIT;
                end else begin
                    // empty numeric column hits bin zero; all else misses
                    cmd.res_set = 1'b1;
                    cmd.res_hit = (i_sts.kind == KIND_NUMERIC);
                    n_state     = ST_IDLE;
                end
            end
            ST_LAST_WAIT: begin
                cmd.rd_zero = 1'b1;
                n_state     = ST_LAST_CMP;
            end
            ST_LAST_CMP: begin
                if (i_sts.below_last) begin
                    cmd.scan_start = 1'b1;
                    n_state        = ST_SCAN;
                end else begin
                    // at or above the last threshold: top bin
                    cmd.res_set = 1'b1;
                    cmd.res_hit = 1'b1;
                    cmd.res_sel = IDX_CNT;
                    n_state     = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (i_sts.match) begin
                    cmd.res_set = 1'b1;
                    cmd.res_hit = 1'b1;
                    cmd.res_sel = IDX_CMP;
                    n_state     = ST_IDLE;
                end else if (i_sts.last) begin
                    // discrete miss, or a numeric scan with no match falling to bin zero
                    cmd.res_set = 1'b1;
                    cmd.res_hit = (i_sts.kind == KIND_NUMERIC);
                    n_state     = ST_IDLE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    // State and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_dp_cmd = cmd;
    assign o_busy   = r_busy;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-hot bin encoder testbench
// Loads column descriptors and entry tables, then encodes values and checks
// each returned position and hit flag against an in-bench predictor of the
// table lookup. Directed corner cases first, then column programs with
// random content, mixed with stray writes and unused command words.
// ----------------------------------------------------------------------------
module tb_top;
    import ohbe_pkg::*;

    localparam int NUM_COLS  = 64;
    localparam int NUM_SLOTS = 32;
    localparam int RAND_WORDS = 400;
    localparam logic [CMD_W-1:0]  OP_NONE    = 2'd3;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [VAL_W-1:0]  Q_ONE      = 32'h0001_0000;
    localparam logic [VAL_W-1:0]  Q_MIN      = 32'h8000_0000;
    localparam logic [VAL_W-1:0]  Q_MAX      = 32'h7fff_ffff;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             hit;
    } t_bin_result;

    // Shadow copy of the descriptor and entry stores, plus the queue of
    // encode results still owed by the block.
    class bin_tracker;
        bit [KIND_W-1:0] col_kind [NUM_COLS];
        int unsigned     col_count[NUM_COLS];
        bit [BASE_W-1:0] col_base [NUM_COLS];
        bit [VAL_W-1:0]  entries  [NUM_COLS*NUM_SLOTS];
        bit              written  [NUM_COLS*NUM_SLOTS];
        t_bin_result     expected_bins[$];
        int              errors;

        function t_bin_result predict_bin(int col, bit [VAL_W-1:0] val);
            t_bin_result r;
            int n;
            int k;
            int idx;
            bit [VAL_W-1:0] last;
            r = '0;
            n = col_count[col];
            if (col_kind[col] == KIND_DISCRETE) begin
                // scan downward so the lowest matching index wins
                for (k = n - 1; k >= 0; k--) begin
                    if (entries[col*NUM_SLOTS + k] == val) begin
                        r.hit = 1'b1;
                        r.position = POS_W'(int'(col_base[col]) + k);
                    end
                end
            end else if (col_kind[col] == KIND_NUMERIC) begin
                idx = 0;
                if (n > 0) begin
                    last = entries[col*NUM_SLOTS + n - 1];
                    if ($signed(val) < $signed(last)) begin
                        for (k = n - 1; k >= 0; k--) begin
                            if ($signed(val) <= $signed(entries[col*NUM_SLOTS + k]))
                                idx = k;
                        end
                    end else begin
                        idx = n;
                    end
                end
                r.hit = 1'b1;
                r.position = POS_W'(int'(col_base[col]) + idx);
            end
            return r;
        endfunction

        // Called for every word the block takes
        function void note_word(bit [CMD_W-1:0] cmd, bit [COL_W-1:0] col,
                                bit [SLOT_W-1:0] slot, bit [KIND_W-1:0] kind,
                                bit [CNT_W-1:0] cnt, bit [BASE_W-1:0] base,
                                bit [VAL_W-1:0] val);
            case (cmd)
                OP_SET_DESC: begin
                    col_kind[col]  = kind;
                    col_count[col] = (cnt > NUM_SLOTS) ? NUM_SLOTS : cnt;
                    col_base[col]  = base;
                end
                OP_WR_ENTRY: begin
                    entries[col*NUM_SLOTS + slot] = val;
                    written[col*NUM_SLOTS + slot] = 1'b1;
                end
                OP_ENCODE: expected_bins = {expected_bins, predict_bin(col, val)};
                default: ;
            endcase
        endfunction

        function void check_result(logic [POS_W-1:0] position, logic hit);
            t_bin_result want;
            if (expected_bins.size() == 0) begin
                errors++;
                $display("%0t: result with none pending: expected nothing, got pos %0d hit %0d",
                         $time, position, hit);
                return;
            end
            want = expected_bins.pop_front();
            if (hit !== want.hit) begin
                errors++;
                $display("%0t: hit mismatch: expected %0d, got %0d", $time, want.hit, hit);
            end
            if (position !== want.position) begin
                errors++;
                $display("%0t: position mismatch: expected %0d, got %0d",
                         $time, want.position, position);
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic [CMD_W-1:0]     i_cmd         = OP_NONE;
    logic [COL_W-1:0]     i_column      = '0;
    logic [SLOT_W-1:0]    i_slot        = '0;
    logic [KIND_W-1:0]    i_kind        = KIND_IGNORED;
    logic [CNT_W-1:0]     i_entry_count = '0;
    logic [BASE_W-1:0]    i_base        = '0;
    logic signed [VAL_W-1:0] i_value    = '0;
    logic                 busy;
    logic [POS_W-1:0]     o_position;
    logic                 o_hit;
    logic                 o_valid;

    bin_tracker board;
    int idle_pct;
    int word_count;

    one_hot_bin_encoder_top #(
        .COLUMNS(NUM_COLS),
        .ENTRIES(NUM_SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_column     (i_column),
        .i_slot       (i_slot),
        .i_kind       (i_kind),
        .i_entry_count(i_entry_count),
        .i_base       (i_base),
        .i_value      (i_value),
        .o_position   (o_position),
        .o_hit        (o_hit),
        .o_valid      (o_valid)
    );

    always #5 i_clk = ~i_clk;

    // Result words are taken at the edge that ends their strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result(o_position, o_hit);
    end

    // Present one word and hold it until the block takes it
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [COL_W-1:0] col,
                             input logic [SLOT_W-1:0] slot, input logic [KIND_W-1:0] kind,
                             input logic [CNT_W-1:0] cnt, input logic [BASE_W-1:0] base,
                             input logic [VAL_W-1:0] val);
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_column      <= col;
        i_slot        <= slot;
        i_kind        <= kind;
        i_entry_count <= cnt;
        i_base        <= base;
        i_value       <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        board.note_word(cmd, col, slot, kind, cnt, base, val);
        if (cmd != OP_NONE)
            word_count++;
        // random idle burst after the word
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic put_desc(input logic [COL_W-1:0] col, input logic [KIND_W-1:0] kind,
                            input logic [CNT_W-1:0] cnt, input logic [BASE_W-1:0] base);
        send_word(OP_SET_DESC, col, SLOT_W'($urandom), kind, cnt, base, $urandom);
    endtask

    task automatic put_entry(input logic [COL_W-1:0] col, input logic [SLOT_W-1:0] slot,
                             input logic [VAL_W-1:0] val);
        send_word(OP_WR_ENTRY, col, slot, KIND_W'($urandom), CNT_W'($urandom),
                  BASE_W'($urandom), val);
    endtask

    // Never let an encode scan a table slot that was not written
    task automatic fill_missing(input logic [COL_W-1:0] col);
        int k;
        for (k = 0; k < board.col_count[col]; k++) begin
            if (!board.written[col*NUM_SLOTS + k])
                put_entry(col, k[SLOT_W-1:0], $urandom);
        end
    endtask

    task automatic put_encode(input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val);
        fill_missing(col);
        send_word(OP_ENCODE, col, SLOT_W'($urandom), KIND_W'($urandom), CNT_W'($urandom),
                  BASE_W'($urandom), val);
    endtask

    // Encode operand: mostly a stored entry or its neighbor, sometimes extremes
    function automatic logic [VAL_W-1:0] pick_value(logic [COL_W-1:0] col);
        int n;
        logic [VAL_W-1:0] e;
        n = board.col_count[col];
        e = (n > 0) ? board.entries[col*NUM_SLOTS + $urandom_range(0, n - 1)] : '0;
        case ($urandom_range(0, 9))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return $urandom;
            3: return e - 1;
            4: return e + 1;
            default: return e;
        endcase
    endfunction

    // Descriptor, full table, then a few encodes on one column
    task automatic program_column(input logic [COL_W-1:0] col);
        logic [KIND_W-1:0] kind;
        int cnt;
        int n;
        int mode;
        int k;
        longint cur;
        longint lim;
        case ($urandom_range(0, 19))
            0: kind = KIND_IGNORED;
            1: kind = KIND_SPARE;
            default: kind = ($urandom_range(0, 1) != 0) ? KIND_DISCRETE : KIND_NUMERIC;
        endcase
        mode = $urandom_range(0, 19);
        if (mode < 15)
            cnt = $urandom_range(0, 8);
        else if (mode < 19)
            cnt = $urandom_range(9, NUM_SLOTS);
        else
            cnt = $urandom_range(NUM_SLOTS + 1, 63);
        n = (cnt > NUM_SLOTS) ? NUM_SLOTS : cnt;
        put_desc(col, kind, cnt[CNT_W-1:0],
                 ($urandom_range(0, 3) == 0) ? BASE_W'(4095 - $urandom_range(0, 40))
                                             : BASE_W'($urandom));
        // 0: unsorted, 1: tight steps with repeats, 2-4: tight steps, else wide
        mode = $urandom_range(0, 9);
        if (mode > 4)
            cur = longint'($signed($urandom())) / 2 - 64'sd1073741824;
        else
            cur = longint'($signed($urandom()));
        for (k = 0; k < n; k++) begin
            if (mode == 0) begin
                put_entry(col, k[SLOT_W-1:0], $urandom);
            end else begin
                put_entry(col, k[SLOT_W-1:0], cur[VAL_W-1:0]);
                if (mode <= 4) begin
                    cur += $urandom_range((mode == 1) ? 0 : 1, 3);
                end else begin
                    lim = (64'sd2147483647 - cur) / (n - k);
                    if (lim > 0)
                        cur += 1 + longint'($urandom()) % lim;
                end
                if (cur > 64'sd2147483647)
                    cur = 64'sd2147483647;
            end
        end
        repeat ($urandom_range(2, 6)) put_encode(col, pick_value(col));
    endtask

    // Hold off new words until every owed result is back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.expected_bins.size() != 0)
            @(posedge i_clk);
    endtask

    // Watchdog
    initial begin
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int seq;
        board = new();
        idle_pct = 0;
        word_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fresh column after reset is ignored
        put_encode(6'd5, 32'd0);
        // numeric column with no thresholds, base at the top
        put_desc(6'd0, KIND_NUMERIC, 6'd0, 12'd4095);
        put_encode(6'd0, Q_MAX);
        // discrete column holding the extremes
        put_desc(6'd1, KIND_DISCRETE, 6'd3, 12'd10);
        put_entry(6'd1, 5'd0, Q_MIN);
        put_entry(6'd1, 5'd1, 32'd0);
        put_entry(6'd1, 5'd2, Q_MAX);
        put_encode(6'd1, Q_MIN);
        put_encode(6'd1, Q_MAX);
        put_encode(6'd1, 32'd5);
        // numeric column at -1.0 / 1.0 whose positions wrap
        put_desc(6'd63, KIND_NUMERIC, 6'd2, 12'd4094);
        put_entry(6'd63, 5'd0, -Q_ONE);
        put_entry(6'd63, 5'd1, Q_ONE);
        put_encode(6'd63, Q_ONE);
        put_encode(6'd63, 32'd0);
        put_encode(6'd63, Q_MIN);
        // unused kind code acts as ignored
        put_desc(6'd2, KIND_SPARE, 6'd0, 12'd7);
        put_encode(6'd2, 32'd0);
        // unused command code
        send_word(OP_NONE, 6'd1, 5'd0, KIND_NUMERIC, 6'd5, 12'd1, Q_MAX);
        // repeated discrete value: lowest slot wins
        put_desc(6'd3, KIND_DISCRETE, 6'd2, 12'd100);
        put_entry(6'd3, 5'd0, 32'd42);
        put_entry(6'd3, 5'd1, 32'd42);
        put_encode(6'd3, 32'd42);
        // thresholds out of order
        put_desc(6'd4, KIND_NUMERIC, 6'd2, 12'd200);
        put_entry(6'd4, 5'd0, Q_ONE);
        put_entry(6'd4, 5'd1, -Q_ONE);
        put_encode(6'd4, 32'd0);

        // Random: column programs with some stray traffic
        word_count = 0;
        seq = 0;
        while (word_count < RAND_WORDS) begin
            seq++;
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 35;
            endcase
            if (word_count > RAND_WORDS - 60)
                idle_pct = 0;
            if ($urandom_range(0, 99) < 65) begin
                program_column(COL_W'($urandom));
            end else begin
                case ($urandom_range(0, 4))
                    0: put_desc(COL_W'($urandom), KIND_W'($urandom), CNT_W'($urandom),
                                BASE_W'($urandom));
                    1: put_entry(COL_W'($urandom), SLOT_W'($urandom), $urandom);
                    2: send_word(OP_NONE, COL_W'($urandom), SLOT_W'($urandom),
                                 KIND_W'($urandom), CNT_W'($urandom), BASE_W'($urandom),
                                 $urandom);
                    default: begin
                        put_encode(COL_W'($urandom), pick_value(COL_W'($urandom)));
                    end
                endcase
            end
            if (seq % 25 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (NUM_SLOTS + 8) @(posedge i_clk);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
